FILE: hdl/psrb_pkg.sv
`default_nettype none
package psrb_pkg;

	localparam int DEF_REGISTER_COUNT = 8192;

	typedef enum logic [1:0] {
		REQ_RD_CHECK = 2'd0,
		REQ_WR_CHECK = 2'd1,
		REQ_READ     = 2'd2,
		REQ_WRITE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_HOLD  = 2'd0,
		KIND_INPUT = 2'd1,
		KIND_COIL  = 2'd2,
		KIND_DISC  = 2'd3
	} kind_t;

	localparam logic [15:0] ADDR_ENABLE = 16'h0001;
	localparam logic [15:0] ADDR_MODEL  = 16'h0003;
	localparam logic [15:0] ADDR_CLASS  = 16'h0004;
	localparam logic [15:0] ADDR_VREAL  = 16'h0010;
	localparam logic [15:0] ADDR_AREAL  = 16'h0011;
	localparam logic [15:0] ADDR_PWR_HI = 16'h0012;
	localparam logic [15:0] ADDR_PWR_LO = 16'h0013;
	localparam logic [15:0] ADDR_LOAD   = 16'h0024;
	localparam logic [15:0] ADDR_VGOAL  = 16'h0030;
	localparam logic [15:0] ADDR_AGOAL  = 16'h0031;

	localparam logic [15:0] VOLT_LIMIT = 16'd3000;
	localparam logic [15:0] POWER_DIV  = 16'd100;
	localparam logic [15:0] MODEL_ID   = 16'd3010;
	localparam logic [15:0] CLASS_ID   = 16'h4b50;
	localparam logic [15:0] VREAL_INIT = 16'd200;
	localparam logic [15:0] LOAD_INIT  = 16'd100;

	// x / 100 for any 32-bit x as (x * POWER_RECIP) >> POWER_SHIFT
	localparam logic [31:0] POWER_RECIP = 32'd1374389535;
	localparam int          POWER_SHIFT = 37;

	// one port request on the holding store
	typedef struct packed {
		logic        en;
		logic        we;
		logic [15:0] addr;
		logic [15:0] wdata;
	} hold_req_t;

	typedef struct packed {
		logic        en;
		logic        we;
		logic [15:0] addr;
		logic        wbit;
	} coil_req_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] read_value;
		logic        exception;
	} rsp_t;

	function automatic logic [15:0] hold_init(input logic [15:0] addr);
		logic [15:0] v;
		unique case (addr)
			ADDR_MODEL: v = MODEL_ID;
			ADDR_CLASS: v = CLASS_ID;
			ADDR_VREAL: v = VREAL_INIT;
			ADDR_LOAD:  v = LOAD_INIT;
			default:    v = 16'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/psrb_div.sv
`default_nettype none
module psrb_div
	import psrb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dsr_q;

	logic [16:0] shifted;
	logic        fits;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[31]};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && busy_q && cnt_q == 5'd31;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(shifted - {1'b0, dsr_q}) : shifted[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

FILE: hdl/psrb_store.sv
`default_nettype none
module psrb_store
	import psrb_pkg::*;
#(
	parameter int NUM_REGS = DEF_REGISTER_COUNT
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire hold_req_t hold_req,
	input  wire coil_req_t coil_req,
	output logic [15:0]    hold_rdata,
	output logic           coil_rdata,
	output logic           clearing
);

	localparam int AW = $clog2(NUM_REGS);

	logic [15:0] hold_mem [NUM_REGS];
	logic        coil_mem [NUM_REGS];

	logic          clr_busy_q;
	logic [AW-1:0] clr_q;
	logic [15:0]   hold_rdata_q;
	logic          coil_rdata_q;

	logic          h_we;
	logic [AW-1:0] h_addr;
	logic [15:0]   h_wdata;
	logic          c_we;
	logic [AW-1:0] c_addr;
	logic          c_wbit;

	// sweep both stores to their reset contents, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(NUM_REGS - 1))
				clr_busy_q <= 1'b0;
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			h_we    = 1'b1;
			h_addr  = clr_q;
			h_wdata = hold_init(16'(clr_q));
			c_we    = 1'b1;
			c_addr  = clr_q;
			c_wbit  = 1'b0;
		end else begin
			h_we    = hold_req.en & hold_req.we;
			h_addr  = hold_req.addr[AW-1:0];
			h_wdata = hold_req.wdata;
			c_we    = coil_req.en & coil_req.we;
			c_addr  = coil_req.addr[AW-1:0];
			c_wbit  = coil_req.wbit;
		end
	end

	always_ff @(posedge clk) begin
		if (h_we)
			hold_mem[h_addr] <= h_wdata;
		else if (hold_req.en)
			hold_rdata_q <= hold_mem[h_addr];
	end

	always_ff @(posedge clk) begin
		if (c_we)
			coil_mem[c_addr] <= c_wbit;
		else if (coil_req.en)
			coil_rdata_q <= coil_mem[c_addr];
	end

	assign hold_rdata = hold_rdata_q;
	assign coil_rdata = coil_rdata_q;
	assign clearing   = clr_busy_q;

endmodule
`default_nettype wire

FILE: hdl/psrb_seq.sv
`default_nettype none
module psrb_seq
	import psrb_pkg::*;
#(
	parameter int NUM_REGS = DEF_REGISTER_COUNT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [1:0]  reg_kind,
	input  wire logic [15:0] reg_index,
	input  wire logic [15:0] write_value,
	input  wire logic        clearing,
	output hold_req_t        hold_req,
	output coil_req_t        coil_req,
	input  wire logic [15:0] hold_rdata,
	input  wire logic        coil_rdata,
	output div_req_t         div_req,
	input  wire div_rsp_t    div_rsp,
	output rsp_t             res,
	input  wire logic        res_take
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_EXEC, ST_RDWAIT, ST_FETCH, ST_FWAIT, ST_VOLT, ST_MUL1,
		ST_MUL10, ST_DIVGO, ST_DIV1, ST_CURWR, ST_PMUL1, ST_PMUL2, ST_PSCALE,
		ST_PWRHI, ST_PWRLO, ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		F_EN, F_VGOAL, F_AGOAL, F_LOAD, F_VREAL
	} fetch_t;

	function automatic logic [15:0] fetch_addr(input fetch_t sel);
		logic [15:0] a;
		unique case (sel)
			F_EN:    a = ADDR_ENABLE;
			F_VGOAL: a = ADDR_VGOAL;
			F_AGOAL: a = ADDR_AGOAL;
			F_LOAD:  a = ADDR_LOAD;
			F_VREAL: a = ADDR_VREAL;
			default: a = ADDR_ENABLE;
		endcase
		return a;
	endfunction

	state_t      state_q;
	fetch_t      fsel_q;
	fetch_t      fsel_s1;
	logic        fvld_s1;
	logic [15:0] rd_q;
	logic        exc_q;

	req_t        req_q;
	kind_t       kind_q;
	logic [15:0] idx_q;
	logic [15:0] val_q;
	logic        inside_q;
	logic        vstep_q;

	logic [15:0] en_q;
	logic [15:0] vgoal_q;
	logic [15:0] agoal_q;
	logic [15:0] load_q;
	logic [15:0] volt_q;
	logic [15:0] cur_q;
	logic [31:0] ev_q;
	logic [31:0] num_q;
	logic [31:0] vi_q;
	logic [31:0] pw_q;

	logic        accept;
	logic        recalc;
	logic        is_check;
	logic [15:0] vnew;
	logic [15:0] cur_capped;
	logic [31:0] ev_prod;
	logic [31:0] vi_prod;
	logic [47:0] pw_prod;
	logic [63:0] pw_scaled;

	assign req_stall = !(state_q == ST_IDLE && !clearing);
	assign accept    = req_valid && !req_stall;

	assign recalc = idx_q == ADDR_ENABLE || idx_q == ADDR_VGOAL ||
		idx_q == ADDR_AGOAL || idx_q == ADDR_LOAD;
	assign is_check = req_q == REQ_RD_CHECK || req_q == REQ_WR_CHECK;

	assign vnew = (en_q == 16'd0) ? 16'd0 : ((vgoal_q > VOLT_LIMIT) ? VOLT_LIMIT : vgoal_q);
	assign cur_capped = (div_rsp.quotient > 32'(agoal_q)) ? agoal_q : div_rsp.quotient[15:0];
	assign ev_prod = 32'(en_q) * 32'(volt_q);
	assign vi_prod = 32'(volt_q) * 32'(cur_q);
	assign pw_prod = 48'(en_q) * 48'(vi_q);
	// power divided by 100 through a reciprocal multiply
	assign pw_scaled = 64'(pw_q) * 64'(POWER_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fsel_q  <= F_EN;
			fsel_s1 <= F_EN;
			fvld_s1 <= 1'b0;
			rd_q    <= '0;
			exc_q   <= 1'b0;
		end else begin
			fvld_s1 <= state_q == ST_FETCH;
			fsel_s1 <= fsel_q;
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					rd_q   <= '0;
					exc_q  <= is_check && !inside_q;
					fsel_q <= F_EN;
					priority if (is_check) begin
						state_q <= ST_DONE;
					end else if (req_q == REQ_READ) begin
						state_q <= (inside_q && (kind_q == KIND_HOLD ||
							kind_q == KIND_COIL)) ? ST_RDWAIT : ST_DONE;
					end else begin
						state_q <= (inside_q && kind_q == KIND_HOLD && recalc) ?
							ST_FETCH : ST_DONE;
					end
				end
				ST_RDWAIT: begin
					rd_q    <= (kind_q == KIND_HOLD) ? hold_rdata : {15'd0, coil_rdata};
					state_q <= ST_DONE;
				end
				ST_FETCH: begin
					if (fsel_q == F_VREAL)
						state_q <= ST_FWAIT;
					else
						fsel_q <= fetch_t'(fsel_q + 3'd1);
				end
				ST_FWAIT:  state_q <= ST_VOLT;
				ST_VOLT:   state_q <= ST_MUL1;
				ST_MUL1:   state_q <= ST_MUL10;
				ST_MUL10:  state_q <= ST_DIVGO;
				ST_DIVGO:  state_q <= (load_q == 16'd0) ? ST_CURWR : ST_DIV1;
				ST_DIV1: begin
					if (div_rsp.done)
						state_q <= ST_CURWR;
				end
				ST_CURWR:  state_q <= ST_PMUL1;
				ST_PMUL1:  state_q <= ST_PMUL2;
				ST_PMUL2:  state_q <= ST_PSCALE;
				ST_PSCALE: state_q <= ST_PWRHI;
				ST_PWRHI:  state_q <= ST_PWRLO;
				ST_PWRLO:  state_q <= ST_DONE;
				ST_DONE: begin
					if (res_take)
						state_q <= ST_IDLE;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req_t'(req_type);
			kind_q   <= kind_t'(reg_kind);
			idx_q    <= reg_index;
			val_q    <= write_value;
			inside_q <= {1'b0, reg_index} < 17'(NUM_REGS);
			vstep_q  <= reg_index == ADDR_ENABLE || reg_index == ADDR_VGOAL;
		end
		// read data lands in the cycle after the fetch was issued
		if (fvld_s1) begin
			unique case (fsel_s1)
				F_EN:    en_q    <= hold_rdata;
				F_VGOAL: vgoal_q <= hold_rdata;
				F_AGOAL: agoal_q <= hold_rdata;
				F_LOAD:  load_q  <= hold_rdata;
				F_VREAL: volt_q  <= hold_rdata;
				default: en_q    <= hold_rdata;
			endcase
		end
		if (state_q == ST_VOLT && vstep_q)
			volt_q <= vnew;
		if (state_q == ST_MUL1)
			ev_q <= ev_prod;
		if (state_q == ST_MUL10)
			num_q <= (ev_q << 3) + (ev_q << 1);
		if (state_q == ST_DIVGO && load_q == 16'd0)
			cur_q <= agoal_q;
		if (state_q == ST_DIV1 && div_rsp.done)
			cur_q <= cur_capped;
		if (state_q == ST_PMUL1)
			vi_q <= vi_prod;
		if (state_q == ST_PMUL2)
			pw_q <= pw_prod[31:0];
		if (state_q == ST_PSCALE)
			pw_q <= 32'(pw_scaled >> POWER_SHIFT);
	end

	always_comb begin
		hold_req = '0;
		coil_req = '0;
		div_req  = '0;
		unique case (state_q)
			ST_EXEC: begin
				if (inside_q && (req_q == REQ_READ || req_q == REQ_WRITE)) begin
					hold_req.en    = kind_q == KIND_HOLD;
					hold_req.we    = req_q == REQ_WRITE;
					hold_req.addr  = idx_q;
					hold_req.wdata = val_q;
					coil_req.en    = kind_q == KIND_COIL;
					coil_req.we    = req_q == REQ_WRITE;
					coil_req.addr  = idx_q;
					coil_req.wbit  = |val_q;
				end
			end
			ST_FETCH: begin
				hold_req.en   = 1'b1;
				hold_req.addr = fetch_addr(fsel_q);
			end
			ST_VOLT: begin
				hold_req.en    = vstep_q;
				hold_req.we    = vstep_q;
				hold_req.addr  = ADDR_VREAL;
				hold_req.wdata = vnew;
			end
			ST_DIVGO: begin
				div_req.start    = load_q != 16'd0;
				div_req.dividend = num_q;
				div_req.divisor  = load_q;
			end
			ST_CURWR: begin
				hold_req.en    = 1'b1;
				hold_req.we    = 1'b1;
				hold_req.addr  = ADDR_AREAL;
				hold_req.wdata = cur_q;
			end
			ST_PWRHI: begin
				hold_req.en    = 1'b1;
				hold_req.we    = 1'b1;
				hold_req.addr  = ADDR_PWR_HI;
				hold_req.wdata = pw_q[31:16];
			end
			ST_PWRLO: begin
				hold_req.en    = 1'b1;
				hold_req.we    = 1'b1;
				hold_req.addr  = ADDR_PWR_LO;
				hold_req.wdata = pw_q[15:0];
			end
			default: begin
				hold_req = '0;
			end
		endcase
	end

	assign res.valid      = state_q == ST_DONE;
	assign res.read_value = rd_q;
	assign res.exception  = exc_q;

endmodule
`default_nettype wire

FILE: hdl/power_supply_register_bank.sv
`default_nettype none
// channel   handshake             payload
// request   req_valid/req_stall   req_type, reg_kind, reg_index, write_value
// response  rsp_valid/rsp_stall   read_value, exception
//
// checks, plain writes and out-of-range accesses: EXEC then DONE; store reads add RDWAIT
// writes to enable, voltage goal, current goal or load rerun the output math,
// waiting on the 32-step divider for the current (skipped at zero load)
// after reset the stores are swept with req_stall high
// the response register holds a stalled beat while the next request is taken
module power_supply_register_bank
	import psrb_pkg::*;
#(
	parameter int REGISTER_COUNT = DEF_REGISTER_COUNT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [1:0]  reg_kind,
	input  wire logic [15:0] reg_index,
	input  wire logic [15:0] write_value,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [15:0]      read_value,
	output logic             exception
);

	hold_req_t   hold_req;
	coil_req_t   coil_req;
	logic [15:0] hold_rdata;
	logic        coil_rdata;
	logic        clearing;
	div_req_t    div_req;
	div_rsp_t    div_rsp;
	rsp_t        res;
	logic        res_take;

	logic        rsp_valid_q;
	logic [15:0] read_value_q;
	logic        exception_q;

	psrb_store #(
		.NUM_REGS (REGISTER_COUNT)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold_req   (hold_req),
		.coil_req   (coil_req),
		.hold_rdata (hold_rdata),
		.coil_rdata (coil_rdata),
		.clearing   (clearing)
	);

	psrb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	psrb_seq #(
		.NUM_REGS (REGISTER_COUNT)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.reg_kind    (reg_kind),
		.reg_index   (reg_index),
		.write_value (write_value),
		.clearing    (clearing),
		.hold_req    (hold_req),
		.coil_req    (coil_req),
		.hold_rdata  (hold_rdata),
		.coil_rdata  (coil_rdata),
		.div_req     (div_req),
		.div_rsp     (div_rsp),
		.res         (res),
		.res_take    (res_take)
	);

	// response register takes a beat when empty or draining
	assign res_take = res.valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			read_value_q <= res.read_value;
			exception_q  <= res.exception;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign read_value = read_value_q;
	assign exception  = exception_q;

endmodule
`default_nettype wire
